### src/mvp_pkg.sv
// ----------------------------------------------------------------------------
// mvp_pkg
// Shared types and constants for the wheel-speed PID controller with odometry.
// ----------------------------------------------------------------------------
package mvp_pkg;

  typedef enum logic [1:0] {
    ACT_SET_TARGET = 2'd0,
    ACT_SAMPLE     = 2'd1,
    ACT_DIR_CHANGE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_INT_LIMIT  = 3'd3,
    REG_DUTY_BIAS  = 3'd4,
    REG_FWD_LEVEL  = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] GainPRst     = 16'd896;
  localparam logic [15:0] GainIRst     = 16'd435;
  localparam logic [15:0] GainDRst     = 16'd435;
  localparam logic [14:0] IntLimitRst  = 15'd10000;
  localparam logic [7:0]  DutyBiasRst  = 8'd80;
  localparam logic        FwdLevelRst  = 1'b0;
  localparam logic [7:0]  DutyMax      = 8'd255;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [14:0] int_limit;
    logic [7:0]  duty_bias;
    logic        fwd_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] target_speed;
    logic               direction_cmd;
    logic [14:0]        encoder_count;
    logic               sensed_direction;
  } item_t;

  typedef struct packed {
    logic [7:0]         pwm_duty;
    logic               motor_dir_pin;
    logic signed [15:0] odometry;
  } result_t;

  typedef struct packed {
    logic signed [16:0] error;
    logic signed [15:0] integ;
    logic [7:0]         duty;
    logic               err_nz;
  } pid_res_t;

endpackage

### src/mvp_if.sv
// ----------------------------------------------------------------------------
// mvp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface mvp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] target_speed;
  logic               direction_cmd;
  logic [14:0]        encoder_count;
  logic               sensed_direction;

  modport source (output valid, action, target_speed, direction_cmd, encoder_count,
                  sensed_direction, input ready);
  modport sink   (input valid, action, target_speed, direction_cmd, encoder_count,
                  sensed_direction, output ready);
endinterface

interface mvp_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         pwm_duty;
  logic               motor_dir_pin;
  logic signed [15:0] odometry;

  modport source (output valid, pwm_duty, motor_dir_pin, odometry, input ready);
  modport sink   (input valid, pwm_duty, motor_dir_pin, odometry, output ready);
endinterface

### src/motor_velocity_pid_with_odometry_unit.sv
// ----------------------------------------------------------------------------
// motor_velocity_pid_with_odometry_unit
// Wheel-speed PID controller with odometry, one result item per command item.
// ----------------------------------------------------------------------------
// Takes one command item per clock unless the output stalls and returns one
// result item for each, in order. An item is captured in an input register;
// when the result register is free or draining, the single combinational pass
// (parallel 17x17, 16x17 and 18x17 multipliers, clamp, sum and saturation)
// updates the controller state and loads the result register. The output
// register lets a new item enter while an earlier result waits. There is no
// clearing pass after reset. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module motor_velocity_pid_with_odometry_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mvp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mvp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  mvp_in_if.sink                        in_i,
  mvp_out_if.source                     out_o
);

  mvp_pkg::cfg_t    cfg;
  mvp_pkg::item_t   in_q;
  mvp_pkg::result_t res;
  mvp_pkg::result_t out_q;
  logic             in_vld_q;
  logic             out_vld_q;
  logic             adv;
  logic             in_rdy;

  mvp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mvp_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Advance when the result register is free or being drained.
  assign adv    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_rdy = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.valid && in_rdy) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_rdy) begin
      in_q.action           <= in_i.action;
      in_q.target_speed     <= in_i.target_speed;
      in_q.direction_cmd    <= in_i.direction_cmd;
      in_q.encoder_count    <= in_i.encoder_count;
      in_q.sensed_direction <= in_i.sensed_direction;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign in_i.ready          = in_rdy;
  assign out_o.valid         = out_vld_q;
  assign out_o.pwm_duty      = out_q.pwm_duty;
  assign out_o.motor_dir_pin = out_q.motor_dir_pin;
  assign out_o.odometry      = out_q.odometry;

`ifndef SYNTH
  // Hold the input stage while a full result register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while pipeline is blocked");

  // Every advanced item produces a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced item produced no result");

  // A new target clears odometry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.action == mvp_pkg::ACT_SET_TARGET) |=> (out_q.odometry == '0))
    else $error("odometry not cleared on set target");

  // A zero target forces the duty to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.action == mvp_pkg::ACT_SET_TARGET && in_q.target_speed == '0)
    |=> (out_q.pwm_duty == '0))
    else $error("duty not zero after zero target");
`endif

endmodule

### src/mvp_cfg_regs.sv
// ----------------------------------------------------------------------------
// mvp_cfg_regs
// Configuration register file: gains, integral limit, offset, forward level.
// ----------------------------------------------------------------------------
module mvp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mvp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mvp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output mvp_pkg::cfg_t                 cfg_o
);

  mvp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= mvp_pkg::GainPRst;
      cfg_q.gain_i     <= mvp_pkg::GainIRst;
      cfg_q.gain_d     <= mvp_pkg::GainDRst;
      cfg_q.int_limit  <= mvp_pkg::IntLimitRst;
      cfg_q.duty_bias  <= mvp_pkg::DutyBiasRst;
      cfg_q.fwd_level  <= mvp_pkg::FwdLevelRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mvp_pkg::REG_GAIN_P:     cfg_q.gain_p     <= cfg_wdata_i;
        mvp_pkg::REG_GAIN_I:     cfg_q.gain_i     <= cfg_wdata_i;
        mvp_pkg::REG_GAIN_D:     cfg_q.gain_d     <= cfg_wdata_i;
        mvp_pkg::REG_INT_LIMIT:  cfg_q.int_limit  <= cfg_wdata_i[14:0];
        mvp_pkg::REG_DUTY_BIAS:  cfg_q.duty_bias  <= cfg_wdata_i[7:0];
        mvp_pkg::REG_FWD_LEVEL:  cfg_q.fwd_level  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/mvp_pid.sv
// ----------------------------------------------------------------------------
// mvp_pid
// One PID step: error, clamped integral, three Q8.8 products, saturated duty.
// ----------------------------------------------------------------------------
module mvp_pid (
  input  logic signed [15:0] target_i,
  input  logic signed [15:0] integ_i,
  input  logic signed [16:0] last_err_i,
  input  logic [14:0]        count_i,
  input  mvp_pkg::cfg_t      cfg_i,
  output mvp_pkg::pid_res_t  res_o
);

  logic signed [16:0] error;
  logic signed [17:0] acc_raw;
  logic signed [17:0] lim;
  logic signed [17:0] acc_clamped;
  logic signed [15:0] acc;
  logic signed [17:0] delta;
  logic signed [33:0] p_prod;
  logic signed [32:0] i_prod;
  logic signed [34:0] d_prod;
  logic signed [36:0] sum;
  logic signed [28:0] pid;
  logic signed [29:0] duty_w;
  logic [7:0]         duty;

  assign error   = 17'(target_i) - $signed({2'b00, count_i});
  assign acc_raw = 18'(integ_i) + 18'(error);
  assign lim     = $signed({3'b000, cfg_i.int_limit});

  always_comb begin
    if (acc_raw > lim) begin
      acc_clamped = lim;
    end else if (acc_raw < -lim) begin
      acc_clamped = -lim;
    end else begin
      acc_clamped = acc_raw;
    end
  end

  assign acc   = acc_clamped[15:0];
  assign delta = 18'(error) - 18'(last_err_i);

  assign p_prod = error * $signed({1'b0, cfg_i.gain_p});
  assign i_prod = acc   * $signed({1'b0, cfg_i.gain_i});
  assign d_prod = delta * $signed({1'b0, cfg_i.gain_d});

  assign sum = 37'(p_prod) + 37'(i_prod) + 37'(d_prod);

  // Shift right by 8, rounding negative values toward zero.
  assign pid = sum[36:8] + {28'd0, (sum[36] & (|sum[7:0]))};

  assign duty_w = 30'(pid) + $signed({22'd0, cfg_i.duty_bias});

  always_comb begin
    if (duty_w[29]) begin
      duty = '0;
    end else if (duty_w >= $signed({22'd0, mvp_pkg::DutyMax})) begin
      duty = mvp_pkg::DutyMax;
    end else begin
      duty = duty_w[7:0];
    end
  end

  assign res_o.error  = error;
  assign res_o.integ  = acc;
  assign res_o.duty   = duty;
  assign res_o.err_nz = (error != '0);

endmodule

### src/mvp_state.sv
// ----------------------------------------------------------------------------
// mvp_state
// Controller state: target, integral, last error, duty, odometry, direction.
// ----------------------------------------------------------------------------
module mvp_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  mvp_pkg::item_t     item_i,
  input  mvp_pkg::cfg_t      cfg_i,
  output mvp_pkg::result_t   res_o
);

  logic signed [15:0] target_q,   target_d;
  logic signed [15:0] integ_q,    integ_d;
  logic signed [16:0] last_err_q, last_err_d;
  logic [7:0]         duty_q,     duty_d;
  logic signed [15:0] odo_q,      odo_d;
  logic               run_dir_q,  run_dir_d;
  logic               dir_pin_q,  dir_pin_d;

  logic signed [15:0] odo_fold;
  mvp_pkg::pid_res_t  pid;

  mvp_pid u_pid (
    .target_i   (target_q),
    .integ_i    (integ_q),
    .last_err_i (last_err_q),
    .count_i    (item_i.encoder_count),
    .cfg_i      (cfg_i),
    .res_o      (pid)
  );

  // Add while running forward, subtract otherwise; wraps at 16 bits.
  assign odo_fold = (run_dir_q == cfg_i.fwd_level) ?
                    odo_q + $signed({1'b0, item_i.encoder_count}) :
                    odo_q - $signed({1'b0, item_i.encoder_count});

  always_comb begin
    target_d   = target_q;
    integ_d    = integ_q;
    last_err_d = last_err_q;
    duty_d     = duty_q;
    odo_d      = odo_q;
    run_dir_d  = run_dir_q;
    dir_pin_d  = dir_pin_q;
    unique case (item_i.action)
      mvp_pkg::ACT_SET_TARGET: begin
        target_d  = item_i.target_speed;
        dir_pin_d = cfg_i.fwd_level ^ item_i.direction_cmd;
        odo_d     = '0;
        if (item_i.target_speed == '0) begin
          integ_d = '0;
          duty_d  = '0;
        end
      end
      mvp_pkg::ACT_SAMPLE: begin
        odo_d      = odo_fold;
        integ_d    = pid.integ;
        last_err_d = pid.error;
        if (pid.err_nz) begin
          duty_d = pid.duty;
        end
      end
      mvp_pkg::ACT_DIR_CHANGE: begin
        odo_d     = odo_fold;
        run_dir_d = item_i.sensed_direction;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      integ_q    <= '0;
      last_err_q <= '0;
      duty_q     <= '0;
      odo_q      <= '0;
      run_dir_q  <= mvp_pkg::FwdLevelRst;
      dir_pin_q  <= mvp_pkg::FwdLevelRst;
    end else if (adv_i) begin
      target_q   <= target_d;
      integ_q    <= integ_d;
      last_err_q <= last_err_d;
      duty_q     <= duty_d;
      odo_q      <= odo_d;
      run_dir_q  <= run_dir_d;
      dir_pin_q  <= dir_pin_d;
    end
  end

  // Result reflects the state after this item.
  assign res_o.pwm_duty      = duty_d;
  assign res_o.motor_dir_pin = dir_pin_d;
  assign res_o.odometry      = odo_d;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wheel-speed PID controller with odometry: a
// directed table of commands, then randomized set-target/sample bursts under
// several register settings, each result item compared with its table value or
// an in-bench controller model while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] ActUnused  = 2'd3;
  localparam int         HoldCycles = 150;
  localparam int         StallLimit = 3000;
  localparam int         PhaseItems = 320;

  typedef struct {
    mvp_pkg::item_t   stim;
    bit               typed;
    mvp_pkg::result_t want;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                         cfg_we;
  logic [mvp_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [mvp_pkg::CfgDataW-1:0] cfg_wdata;

  mvp_in_if  cmd_if ();
  mvp_out_if res_if ();

  motor_velocity_pid_with_odometry_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // controller model: configuration and state
  logic [15:0]        cfg_gp  = mvp_pkg::GainPRst;
  logic [15:0]        cfg_gi  = mvp_pkg::GainIRst;
  logic [15:0]        cfg_gd  = mvp_pkg::GainDRst;
  logic [14:0]        cfg_lim = mvp_pkg::IntLimitRst;
  logic [7:0]         cfg_off = mvp_pkg::DutyBiasRst;
  logic               cfg_fwd = mvp_pkg::FwdLevelRst;
  int                 ctl_target   = 0;
  int                 ctl_integ    = 0;
  int                 ctl_last_err = 0;
  logic [7:0]         ctl_duty     = '0;
  logic [15:0]        ctl_odo      = '0;
  logic               ctl_run_dir  = mvp_pkg::FwdLevelRst;
  logic               ctl_dir_pin  = mvp_pkg::FwdLevelRst;

  mvp_pkg::result_t expected_results[$];
  int      mismatches   = 0;
  int      stall_cycles = 0;
  bit      tx_steady    = 1'b0;
  bit      rx_steady    = 1'b0;
  bit      hold_req     = 1'b0;
  int      hold_left    = 0;

  function automatic void fold_count(int cnt);
    if (ctl_run_dir == cfg_fwd) ctl_odo = ctl_odo + 16'(cnt);
    else ctl_odo = ctl_odo - 16'(cnt);
  endfunction

  function automatic mvp_pkg::result_t predict_controller(mvp_pkg::item_t it);
    int      cnt;
    int      err;
    int      acc;
    int      lim;
    int      dlt;
    longint  sum;
    longint  pid;
    longint  dty;
    mvp_pkg::result_t r;
    cnt = int'(it.encoder_count);
    case (it.action)
      mvp_pkg::ACT_SET_TARGET: begin
        ctl_target  = int'($signed(it.target_speed));
        ctl_dir_pin = it.direction_cmd ? ~cfg_fwd : cfg_fwd;
        ctl_odo     = '0;
        if (ctl_target == 0) begin
          ctl_integ = 0;
          ctl_duty  = '0;
        end
      end
      mvp_pkg::ACT_SAMPLE: begin
        fold_count(cnt);
        err = ctl_target - cnt;
        lim = int'(cfg_lim);
        acc = ctl_integ + err;
        if (acc > lim) acc = lim;
        else if (acc < -lim) acc = -lim;
        ctl_integ    = acc;
        dlt          = err - ctl_last_err;
        ctl_last_err = err;
        sum = longint'(err) * longint'(cfg_gp) + longint'(acc) * longint'(cfg_gi)
            + longint'(dlt) * longint'(cfg_gd);
        // signed division truncates toward zero
        pid = sum / 256;
        if (err != 0) begin
          dty = pid + longint'(cfg_off);
          if (dty >= 255) dty = 255;
          else if (dty < 0) dty = 0;
          ctl_duty = 8'(dty);
        end
      end
      mvp_pkg::ACT_DIR_CHANGE: begin
        fold_count(cnt);
        ctl_run_dir = it.sensed_direction;
      end
      default: ;
    endcase
    r.pwm_duty      = ctl_duty;
    r.motor_dir_pin = ctl_dir_pin;
    r.odometry      = ctl_odo;
    return r;
  endfunction

  function automatic mvp_pkg::item_t mk_item(logic [1:0] act, int tgt, bit dcmd, int cnt,
                                             bit sens);
    mvp_pkg::item_t it;
    it.action           = act;
    it.target_speed     = 16'(tgt);
    it.direction_cmd    = dcmd;
    it.encoder_count    = 15'(cnt);
    it.sensed_direction = sens;
    return it;
  endfunction

  function automatic vec_row_t vrow(mvp_pkg::item_t s, bit t, logic [7:0] d, logic p, int o);
    vec_row_t v;
    v.stim               = s;
    v.typed              = t;
    v.want.pwm_duty      = d;
    v.want.motor_dir_pin = p;
    v.want.odometry      = 16'(o);
    return v;
  endfunction

  task automatic send_item(mvp_pkg::item_t it, bit use_typed = 1'b0,
                           mvp_pkg::result_t typed = '0);
    mvp_pkg::result_t predicted;
    while (!tx_steady && $urandom_range(99) < 28) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid            <= 1'b1;
    cmd_if.action           <= it.action;
    cmd_if.target_speed     <= it.target_speed;
    cmd_if.direction_cmd    <= it.direction_cmd;
    cmd_if.encoder_count    <= it.encoder_count;
    cmd_if.sensed_direction <= it.sensed_direction;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predicted = predict_controller(it);
    expected_results.push_back(use_typed ? typed : predicted);
  endtask

  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(mvp_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      mvp_pkg::REG_GAIN_P:     cfg_gp  = val;
      mvp_pkg::REG_GAIN_I:     cfg_gi  = val;
      mvp_pkg::REG_GAIN_D:     cfg_gd  = val;
      mvp_pkg::REG_INT_LIMIT:  cfg_lim = val[14:0];
      mvp_pkg::REG_DUTY_BIAS:  cfg_off = val[7:0];
      mvp_pkg::REG_FWD_LEVEL:  cfg_fwd = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                         logic [14:0] lim, logic [7:0] off, logic fwd);
    write_reg(mvp_pkg::REG_GAIN_P, gp);
    write_reg(mvp_pkg::REG_GAIN_I, gi);
    write_reg(mvp_pkg::REG_GAIN_D, gd);
    write_reg(mvp_pkg::REG_INT_LIMIT, 16'(lim));
    write_reg(mvp_pkg::REG_DUTY_BIAS, 16'(off));
    write_reg(mvp_pkg::REG_FWD_LEVEL, 16'(fwd));
    cfg_we <= 1'b0;
  endtask

  // mostly set-target followed by a run of samples near the target, rest noise
  task automatic run_random(int n);
    int    sent;
    int    tgt;
    int    mag;
    int    len;
    int    cnt;
    int    pick;
    bit    dcmd;
    mvp_pkg::item_t it;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        pick = $urandom_range(99);
        if (pick < 10) tgt = 0;
        else if (pick < 75) tgt = $urandom_range(600) - 300;
        else tgt = int'($signed(16'($urandom)));
        dcmd = (tgt < 0) ^ ($urandom_range(9) == 0);
        send_item(mk_item(mvp_pkg::ACT_SET_TARGET, tgt, dcmd, $urandom_range(32767),
                          1'($urandom_range(1))));
        sent++;
        mag = (tgt < 0) ? -tgt : tgt;
        len = $urandom_range(12, 2);
        for (int k = 0; k < len && sent < n; k++) begin
          cnt = mag + $urandom_range(40) - 20;
          if (cnt < 0) cnt = 0;
          if (cnt > 32767) cnt = 32767;
          if ($urandom_range(9) == 0)
            send_item(mk_item(mvp_pkg::ACT_DIR_CHANGE, $urandom, 1'($urandom_range(1)),
                              cnt, 1'($urandom_range(1))));
          else
            send_item(mk_item(mvp_pkg::ACT_SAMPLE, $urandom, 1'($urandom_range(1)),
                              cnt, 1'($urandom_range(1))));
          sent++;
        end
      end else begin
        it = mk_item(2'($urandom_range(3)), $urandom, 1'($urandom_range(1)),
                     $urandom_range(32767), 1'($urandom_range(1)));
        send_item(it);
        if (it.action != ActUnused) sent++;
      end
    end
  endtask

  // receiver: random stalls, steady stretches, and one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (rx_steady) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk) begin : check_results
    mvp_pkg::result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: duty %0d pin %0d odometry %0d",
                   res_if.pwm_duty, res_if.motor_dir_pin, res_if.odometry);
      end else begin
        want = expected_results.pop_front();
        if (res_if.pwm_duty !== want.pwm_duty || res_if.motor_dir_pin !== want.motor_dir_pin
            || res_if.odometry !== want.odometry) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected duty %0d pin %0d odometry %0d, got %0d %0d %0d",
                     want.pwm_duty, want.motor_dir_pin, want.odometry,
                     res_if.pwm_duty, res_if.motor_dir_pin, res_if.odometry);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no item moved for %0d cycles", StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : main
    vec_row_t dir_vecs [23];
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = '0;
    cfg_wdata               = '0;
    cmd_if.valid            = 1'b0;
    cmd_if.action           = mvp_pkg::ACT_SET_TARGET;
    cmd_if.target_speed     = '0;
    cmd_if.direction_cmd    = 1'b0;
    cmd_if.encoder_count    = '0;
    cmd_if.sensed_direction = 1'b0;
    res_if.ready            = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_vecs = '{
      vrow(mk_item(ActUnused,               0,      0, 0,     0), 1, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SET_TARGET, 0,      0, 0,     0), 1, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SET_TARGET, 100,    1, 0,     0), 1, 0,   1, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 100,   0), 1, 0,   1, 100),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 0,     0), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 32767, 0), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_DIR_CHANGE, 0,      0, 5,     1), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 10,    0), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_DIR_CHANGE, 0,      0, 32767, 0), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SET_TARGET, -32768, 0, 0,     0), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 32767, 0), 1, 0,   0, 32767),
      vrow(mk_item(mvp_pkg::ACT_SET_TARGET, 32767,  1, 0,     0), 1, 0,   1, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 0,     0), 1, 255, 1, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 0,     0), 1, 255, 1, 0),
      vrow(mk_item(mvp_pkg::ACT_SET_TARGET, 0,      0, 0,     0), 1, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 0,     0), 1, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 50,    0), 0, 0,   0, 0),
      vrow(mk_item(ActUnused,               -1,     1, 32767, 1), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SET_TARGET, 1,      0, 0,     0), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 1,     0), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 2,     0), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_DIR_CHANGE, 0,      0, 0,     1), 0, 0,   0, 0),
      vrow(mk_item(mvp_pkg::ACT_SAMPLE,     0,      0, 3,     0), 0, 0,   0, 0)
    };
    foreach (dir_vecs[i])
      send_item(dir_vecs[i].stim, dir_vecs[i].typed, dir_vecs[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      // hold input until every result is back before touching registers
      wait_idle();
      case (ph)
        1: set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 8'hFF, 1'b1);
        2: set_all(16'h0000, 16'h0000, 16'h0000, 15'h0000, 8'h00, 1'b0);
        3, 4: set_all(16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
                      8'($urandom), 1'($urandom));
        5: set_all(16'($urandom_range(2048)), 16'($urandom_range(1024)),
                   16'($urandom_range(1024)), 15'($urandom_range(20000)),
                   8'($urandom_range(120)), 1'($urandom_range(1)));
        default: ;
      endcase
      if (ph == 0) begin
        // long receiver hold-off while the sender floods the input
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        run_random(150);
        tx_steady = 1'b0;
        run_random(PhaseItems - 150);
      end else if (ph == 1) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random(150);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        run_random(PhaseItems - 150);
      end else begin
        run_random(PhaseItems);
      end
    end

    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
src/mvp_pkg.sv
src/mvp_if.sv
src/mvp_cfg_regs.sv
src/mvp_pid.sv
src/mvp_state.sv
src/motor_velocity_pid_with_odometry_unit.sv
tb/testbench.sv
